>>> sv/pwe_pkg.sv
// ----------------------------------------------------------------------------
// pwe_pkg
// Shared constants for the pooling window engine: register indexes, reset
// values, pooling mode codes, output range and default parameters.
// ----------------------------------------------------------------------------
package pwe_pkg;

  // default parameter values
  localparam int MAX_DIM_DEF     = 32;
  localparam int MAX_WINDOW_DEF  = 8;
  localparam int SAMPLE_BITS_DEF = 16;

  // configuration register indexes
  localparam logic [2:0] REG_POOL_MODE    = 3'd0;
  localparam logic [2:0] REG_PLANE_WIDTH  = 3'd1;
  localparam logic [2:0] REG_PLANE_HEIGHT = 3'd2;
  localparam logic [2:0] REG_WINDOW_SIZE  = 3'd3;
  localparam logic [2:0] REG_STEP_SIZE    = 3'd4;
  localparam logic [2:0] REG_PAD_AMOUNT   = 3'd5;

  // pooling modes; the unused code pools as maximum
  localparam logic [1:0] MODE_MAX = 2'd0;
  localparam logic [1:0] MODE_AVG = 2'd1;
  localparam logic [1:0] MODE_MIN = 2'd2;

  // register reset values
  localparam logic [1:0] POOL_MODE_RST    = MODE_MAX;
  localparam logic [5:0] PLANE_WIDTH_RST  = 6'd5;
  localparam logic [5:0] PLANE_HEIGHT_RST = 6'd5;
  localparam logic [3:0] WINDOW_SIZE_RST  = 4'd3;
  localparam logic [3:0] STEP_SIZE_RST    = 4'd1;
  localparam logic [2:0] PAD_AMOUNT_RST   = 3'd0;

  // window coordinate width: covers 63*15 plus a window side, signed
  localparam int COORD_W = 12;
  // divisor width: window area of a 4-bit side
  localparam int DIV_W = 8;
  // fraction bits of the result
  localparam int FRAC_W = 8;

  localparam int OUT_MAX = 8388607;
  localparam int OUT_MIN = -8388608;

endpackage

>>> sv/pwe_div.sv
// ----------------------------------------------------------------------------
// pwe_div
// Restoring divider for the window average: one quotient bit per cycle,
// dividend is the sum magnitude with fraction bits appended, result signed
// and truncated toward zero.
// ----------------------------------------------------------------------------
module pwe_div #(
  parameter int MAG_W = 24
) (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    start,
  input  logic                                    neg,
  input  logic [MAG_W-1:0]                        mag,
  input  logic [pwe_pkg::DIV_W-1:0]               divisor,
  output logic                                    done,
  output logic signed [MAG_W+pwe_pkg::FRAC_W:0]   quotient
);

  localparam int QW   = MAG_W + pwe_pkg::FRAC_W;
  localparam int CNTW = $clog2(QW + 1);
  localparam int DW   = pwe_pkg::DIV_W;

  logic [QW-1:0]   acc;
  logic [DW-1:0]   rem;
  logic [DW-1:0]   dvs;
  logic            neg_q;
  logic [CNTW-1:0] cnt;

  logic [DW:0]     cand;
  logic            fits;
  logic [DW-1:0]   rem_next;

  always_comb begin
    cand     = {rem, acc[QW-1]};
    fits     = cand >= {1'b0, dvs};
    rem_next = fits ? DW'(cand - {1'b0, dvs}) : cand[DW-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        cnt <= CNTW'(QW);
      end else if (cnt != '0) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNTW'(1)) begin
          done <= 1'b1;
        end
      end
    end
  end

  // quotient bits shift in where the dividend bits leave
  always_ff @(posedge clk) begin
    if (start) begin
      acc   <= {mag, {pwe_pkg::FRAC_W{1'b0}}};
      rem   <= '0;
      dvs   <= divisor;
      neg_q <= neg;
    end else if (cnt != '0) begin
      acc <= {acc[QW-2:0], fits};
      rem <= rem_next;
    end
  end

  assign quotient = neg_q ? -$signed({1'b0, acc}) : $signed({1'b0, acc});

endmodule

>>> sv/pooling_window_engine.sv
// ----------------------------------------------------------------------------
// pooling_window_engine
// 2-D maximum / average / minimum pooling over one sample plane held in an
// internal synchronous store, with zero padding and saturated Q.8 results.
// ----------------------------------------------------------------------------
// Load: no result. Empty window: done rises at the accepting edge. Compute,
// maximum or minimum: S_READ walks the window (k = window side), one store
// read per window position inside the plane, then S_WAIT and S_FIN. Average
// adds the serial divider in S_DIV. New items are taken only while idle.
// Reset clears the registers to their defaults and idles the engine; the
// sample store is not cleared. Results cannot be stalled.
module pooling_window_engine #(
  parameter int MAX_DIM     = pwe_pkg::MAX_DIM_DEF,
  parameter int MAX_WINDOW  = pwe_pkg::MAX_WINDOW_DEF,
  parameter int SAMPLE_BITS = pwe_pkg::SAMPLE_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic               op,
  input  logic [4:0]         in_row,
  input  logic [4:0]         in_col,
  input  logic signed [15:0] sample,
  input  logic [5:0]         out_row,
  input  logic [5:0]         out_col,
  input  logic               wr_en,
  input  logic [2:0]         wr_index,
  input  logic [5:0]         wr_data,
  output logic               done,
  output logic signed [23:0] pooled_value
);

  localparam int DEPTH = MAX_DIM * MAX_DIM;
  localparam int AW    = $clog2(DEPTH);
  localparam int RIW   = $clog2(MAX_DIM);
  localparam int CW    = pwe_pkg::COORD_W;
  localparam int SUMW  = SAMPLE_BITS + 8;
  localparam int RW    = SUMW + pwe_pkg::FRAC_W + 1;

  localparam logic signed [RW-1:0] SAT_HI = RW'(pwe_pkg::OUT_MAX);
  localparam logic signed [RW-1:0] SAT_LO = RW'(pwe_pkg::OUT_MIN);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_READ = 5'b00010,
    S_WAIT = 5'b00100,
    S_FIN  = 5'b01000,
    S_DIV  = 5'b10000
  } state_t;

  state_t state;

  // configuration
  logic [1:0] pool_mode;
  logic [5:0] plane_width;
  logic [5:0] plane_height;
  logic [3:0] win_side;
  logic [3:0] step_size;
  logic [2:0] pad_amount;

  always_ff @(posedge clk) begin
    if (rst) begin
      pool_mode    <= pwe_pkg::POOL_MODE_RST;
      plane_width  <= pwe_pkg::PLANE_WIDTH_RST;
      plane_height <= pwe_pkg::PLANE_HEIGHT_RST;
      win_side     <= pwe_pkg::WINDOW_SIZE_RST;
      step_size    <= pwe_pkg::STEP_SIZE_RST;
      pad_amount   <= pwe_pkg::PAD_AMOUNT_RST;
    end else if (wr_en) begin
      unique case (wr_index)
        pwe_pkg::REG_POOL_MODE:    pool_mode    <= wr_data[1:0];
        pwe_pkg::REG_PLANE_WIDTH:  plane_width  <= wr_data;
        pwe_pkg::REG_PLANE_HEIGHT: plane_height <= wr_data;
        pwe_pkg::REG_WINDOW_SIZE:  win_side     <= wr_data[3:0];
        pwe_pkg::REG_STEP_SIZE:    step_size    <= wr_data[3:0];
        pwe_pkg::REG_PAD_AMOUNT:   pad_amount   <= wr_data[2:0];
        default: ;
      endcase
    end
  end

  // sample store
  logic signed [SAMPLE_BITS-1:0] mem [DEPTH];
  logic                          wr_mem;
  logic [AW-1:0]                 wr_addr;
  logic signed [SAMPLE_BITS-1:0] wr_val;
  logic                          rd_en;
  logic [AW-1:0]                 rd_addr;
  logic signed [SAMPLE_BITS-1:0] rd_data;

  logic accept;
  assign accept = start && !busy;
  assign busy   = state != S_IDLE;

  always_comb begin
    // drop loads that fall outside the store
    wr_mem  = accept && !op
              && (32'(in_row) < MAX_DIM) && (32'(in_col) < MAX_DIM);
    wr_addr = AW'(in_row) * AW'(MAX_DIM) + AW'(in_col);
    wr_val  = SAMPLE_BITS'(sample);
  end

  always_ff @(posedge clk) begin
    if (wr_mem) begin
      mem[wr_addr] <= wr_val;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  // window walk
  logic [CW-1:0] r0_q, c0_q, h_q, w_q;
  logic [3:0]    k_q, i_q, j_q;
  logic [1:0]    mode_q;
  logic [3:0]    k_clip;
  logic [CW-1:0] r_cur, c_cur;
  logic          in_plane;
  logic          last_pos;

  always_comb begin
    k_clip   = (5'(win_side) > 5'(MAX_WINDOW)) ? 4'(MAX_WINDOW) : win_side;
    r_cur    = r0_q + CW'(i_q);
    c_cur    = c0_q + CW'(j_q);
    in_plane = !r_cur[CW-1] && (r_cur < h_q) && !c_cur[CW-1] && (c_cur < w_q);
    last_pos = (i_q == k_q - 1'b1) && (j_q == k_q - 1'b1);
    rd_en    = (state == S_READ) && in_plane;
    rd_addr  = AW'(r_cur[RIW-1:0]) * AW'(MAX_DIM) + AW'(c_cur[RIW-1:0]);
  end

  // read pipeline tags, registered alongside the store read data
  logic rd_vld, rd_inside, rd_last;

  // accumulators
  logic signed [SUMW-1:0]        sum_q;
  logic signed [SAMPLE_BITS-1:0] mx_q, mn_q;
  logic                          first_q;
  logic signed [SAMPLE_BITS-1:0] val;

  assign val = rd_inside ? rd_data : '0;

  always_ff @(posedge clk) begin
    if (accept && op) begin
      r0_q    <= CW'(out_row) * CW'(step_size) - CW'(pad_amount);
      c0_q    <= CW'(out_col) * CW'(step_size) - CW'(pad_amount);
      h_q     <= (CW'(plane_height) > CW'(MAX_DIM)) ? CW'(MAX_DIM) : CW'(plane_height);
      w_q     <= (CW'(plane_width) > CW'(MAX_DIM)) ? CW'(MAX_DIM) : CW'(plane_width);
      k_q     <= k_clip;
      mode_q  <= pool_mode;
      sum_q   <= '0;
      mx_q    <= '0;
      mn_q    <= '0;
      first_q <= 1'b1;
    end else if (rd_vld) begin
      sum_q   <= sum_q + SUMW'(val);
      if (first_q || val > mx_q) mx_q <= val;
      if (first_q || val < mn_q) mn_q <= val;
      first_q <= 1'b0;
    end
  end

  // divider
  logic                   div_start;
  logic                   div_done;
  logic signed [RW-1:0]   div_quot;
  logic [SUMW-1:0]        sum_mag;

  assign sum_mag   = sum_q[SUMW-1] ? SUMW'(-sum_q) : SUMW'(sum_q);
  assign div_start = (state == S_FIN) && (mode_q == pwe_pkg::MODE_AVG);

  pwe_div #(
    .MAG_W (SUMW)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .neg      (sum_q[SUMW-1]),
    .mag      (sum_mag),
    .divisor  (pwe_pkg::DIV_W'(k_q) * pwe_pkg::DIV_W'(k_q)),
    .done     (div_done),
    .quotient (div_quot)
  );

  // result select and saturation
  logic signed [SAMPLE_BITS-1:0] pick;
  logic signed [RW-1:0]          pre;
  logic signed [23:0]            sat_val;
  logic                          done_set;
  logic                          zero_win;

  always_comb begin
    pick = (mode_q == pwe_pkg::MODE_MIN) ? mn_q : mx_q;
    pre  = (state == S_DIV) ? div_quot : (RW'(pick) <<< pwe_pkg::FRAC_W);
    if (pre > SAT_HI) begin
      sat_val = 24'(SAT_HI);
    end else if (pre < SAT_LO) begin
      sat_val = 24'(SAT_LO);
    end else begin
      sat_val = 24'(pre);
    end
  end

  always_comb begin
    zero_win = accept && op && (k_clip == '0);
    done_set = zero_win
               || ((state == S_FIN) && (mode_q != pwe_pkg::MODE_AVG))
               || ((state == S_DIV) && div_done);
  end

  always_ff @(posedge clk) begin
    if (done_set) begin
      pooled_value <= zero_win ? '0 : sat_val;
    end
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      i_q       <= '0;
      j_q       <= '0;
      rd_vld    <= 1'b0;
      rd_inside <= 1'b0;
      rd_last   <= 1'b0;
      done      <= 1'b0;
    end else begin
      done      <= done_set;
      rd_vld    <= state == S_READ;
      rd_inside <= in_plane;
      rd_last   <= last_pos;
      unique case (state)
        S_IDLE: begin
          if (accept && op && (k_clip != '0)) begin
            i_q   <= '0;
            j_q   <= '0;
            state <= S_READ;
          end
        end
        S_READ: begin
          if (j_q == k_q - 1'b1) begin
            j_q <= '0;
            i_q <= i_q + 1'b1;
          end else begin
            j_q <= j_q + 1'b1;
          end
          if (last_pos) begin
            state <= S_WAIT;
          end
        end
        S_WAIT: begin
          // hold until the last sample is folded in
          if (rd_vld && rd_last) begin
            state <= S_FIN;
          end
        end
        S_FIN: begin
          state <= (mode_q == pwe_pkg::MODE_AVG) ? S_DIV : S_IDLE;
        end
        S_DIV: begin
          if (div_done) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_done_ends_item: assert property (@(posedge clk) disable iff (rst)
    done && $past(busy) |-> !busy)
    else $error("result strobe while the engine is still busy");

  a_read_from_walk: assert property (@(posedge clk) disable iff (rst)
    rd_vld |-> $past(state == S_READ))
    else $error("read data tagged valid without a window read");

  a_div_only_avg: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV) |-> (mode_q == pwe_pkg::MODE_AVG))
    else $error("divider running outside average pooling");

  a_no_load_busy: assert property (@(posedge clk) disable iff (rst)
    wr_mem |-> !busy)
    else $error("store written during a window walk");
`endif

endmodule
